### sv/rfg_pkg.sv
// rfg_pkg: shared types and constants for the raster font glyph fetch block
`timescale 1ns / 1ps

package rfg_pkg;

    localparam int VERSION_2 = 'h200;
    localparam int VERSION_3 = 'h300;

    localparam int HDR_VERSION_ADDR = 0;
    localparam int HDR_HEIGHT_ADDR  = 88;
    localparam int HDR_FIRST_ADDR   = 95;
    localparam int HDR_LAST_ADDR    = 96;
    localparam int HDR_DEFAULT_ADDR = 97;

    localparam int V2_TABLE_BASE  = 118;
    localparam int V3_TABLE_BASE  = 148;
    localparam int V2_ENTRY_BYTES = 4;
    localparam int V3_ENTRY_BYTES = 6;

    localparam int HDR_LAST_STEP = 6;
    localparam int V2_LAST_STEP  = V2_ENTRY_BYTES - 1;
    localparam int V3_LAST_STEP  = V3_ENTRY_BYTES - 1;

    typedef enum logic [1:0] {
        FLT_OK      = 2'd0,
        FLT_VERSION = 2'd1,
        FLT_SIZE    = 2'd2,
        FLT_RANGE   = 2'd3
    } fault_t;

    // destination of a font memory read
    typedef enum logic [3:0] {
        DST_NONE,
        DST_VER0,
        DST_VER1,
        DST_H0,
        DST_H1,
        DST_FIRST,
        DST_LAST,
        DST_DFLT,
        DST_W0,
        DST_W1,
        DST_OFS0,
        DST_OFS1,
        DST_OFS2,
        DST_OFS3,
        DST_ROW
    } dst_t;

    typedef struct packed {
        logic        command;
        logic [15:0] load_address;
        logic [7:0]  load_byte;
        logic [20:0] char_code;
    } rfg_in_t;

    typedef struct packed {
        logic [63:0] row_bits;
        logic [5:0]  row_number;
        logic [15:0] glyph_width;
        logic [15:0] glyph_height;
        logic        last_row;
        fault_t      fault;
    } rfg_out_t;

    typedef struct packed {
        dst_t   rd_tag;
        logic   wr_en;
        logic   cap_code;
        logic   eval1;
        logic   eval2;
        logic   eval3;
        logic   row_init;
        logic   row_emit;
        logic   fault_emit;
        fault_t fault_code;
    } rfg_cmd_t;

    typedef struct packed {
        logic ver_bad;
        logic ver3;
        logic below_first;
        logic entry_oob;
        logic size_bad;
        logic bitmap_oob;
        logic k_last;
        logic r_last;
        logic out_free;
    } rfg_status_t;

endpackage

### sv/rfg_ctrl.sv
// rfg_ctrl: sequencer for header, glyph table and bitmap reads
`timescale 1ns / 1ps

module rfg_ctrl import rfg_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_command,
    output logic        s_ready,
    input  rfg_status_t status,
    output rfg_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HDR,
        ST_HDR_WAIT,
        ST_EVAL1,
        ST_CHK1,
        ST_TBL,
        ST_TBL_WAIT,
        ST_EVAL2,
        ST_EVAL3,
        ST_CHK2,
        ST_FETCH,
        ST_DRAIN,
        ST_EMIT,
        ST_FAULT
    } state_t;

    state_t      state_reg, state_next;
    logic [2:0]  step_reg, step_next;
    fault_t      fault_reg, fault_next;
    logic        tbl_done;

    assign tbl_done = status.ver3 ? (step_reg == 3'(V3_LAST_STEP))
                                  : (step_reg == 3'(V2_LAST_STEP));
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        fault_next = fault_reg;
        cmd        = '0;
        cmd.rd_tag = DST_NONE;
        cmd.fault_code = fault_reg;
        unique case (state_reg)
            ST_IDLE: begin
                step_next = '0;
                if (s_valid) begin
                    if (s_command) begin
                        cmd.cap_code = 1'b1;
                        state_next   = ST_HDR;
                    end else begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            ST_HDR: begin
                unique case (step_reg)
                    3'd0:    cmd.rd_tag = DST_VER0;
                    3'd1:    cmd.rd_tag = DST_VER1;
                    3'd2:    cmd.rd_tag = DST_H0;
                    3'd3:    cmd.rd_tag = DST_H1;
                    3'd4:    cmd.rd_tag = DST_FIRST;
                    3'd5:    cmd.rd_tag = DST_LAST;
                    default: cmd.rd_tag = DST_DFLT;
                endcase
                step_next = step_reg + 3'd1;
                if (step_reg == 3'(HDR_LAST_STEP)) begin
                    state_next = ST_HDR_WAIT;
                end
            end
            ST_HDR_WAIT: begin
                state_next = ST_EVAL1;
            end
            ST_EVAL1: begin
                cmd.eval1  = 1'b1;
                state_next = ST_CHK1;
            end
            ST_CHK1: begin
                step_next = '0;
                priority if (status.ver_bad) begin
                    fault_next = FLT_VERSION;
                    state_next = ST_FAULT;
                end else if (status.below_first || status.entry_oob) begin
                    fault_next = FLT_RANGE;
                    state_next = ST_FAULT;
                end else begin
                    state_next = ST_TBL;
                end
            end
            ST_TBL: begin
                unique case (step_reg)
                    3'd0:    cmd.rd_tag = DST_W0;
                    3'd1:    cmd.rd_tag = DST_W1;
                    3'd2:    cmd.rd_tag = DST_OFS0;
                    3'd3:    cmd.rd_tag = DST_OFS1;
                    3'd4:    cmd.rd_tag = DST_OFS2;
                    default: cmd.rd_tag = DST_OFS3;
                endcase
                step_next = step_reg + 3'd1;
                if (tbl_done) begin
                    state_next = ST_TBL_WAIT;
                end
            end
            ST_TBL_WAIT: begin
                state_next = ST_EVAL2;
            end
            ST_EVAL2: begin
                cmd.eval2  = 1'b1;
                state_next = ST_EVAL3;
            end
            ST_EVAL3: begin
                cmd.eval3  = 1'b1;
                state_next = ST_CHK2;
            end
            ST_CHK2: begin
                priority if (status.size_bad) begin
                    fault_next = FLT_SIZE;
                    state_next = ST_FAULT;
                end else if (status.bitmap_oob) begin
                    fault_next = FLT_RANGE;
                    state_next = ST_FAULT;
                end else begin
                    cmd.row_init = 1'b1;
                    state_next   = ST_FETCH;
                end
            end
            ST_FETCH: begin
                cmd.rd_tag = DST_ROW;
                if (status.k_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.row_emit = 1'b1;
                    state_next   = status.r_last ? ST_IDLE : ST_FETCH;
                end
            end
            ST_FAULT: begin
                if (status.out_free) begin
                    cmd.fault_emit = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            fault_reg <= FLT_OK;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            fault_reg <= fault_next;
        end
    end

endmodule

### sv/rfg_datapath.sv
// rfg_datapath: font memory, glyph checks, row assembly and result register
`timescale 1ns / 1ps

module rfg_datapath import rfg_pkg::*; #(
    parameter int FONT_BYTES    = 65536,
    parameter int MAX_ROWS      = 64,
    parameter int MAX_ROW_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  rfg_in_t     s_data,
    input  rfg_cmd_t    cmd,
    output rfg_status_t status,
    output logic        m_valid,
    input  logic        m_ready,
    output rfg_out_t    m_data
);

    localparam int ADDR_W = $clog2(FONT_BYTES);

    logic [7:0]        mem [FONT_BYTES];
    logic [7:0]        rd_data_reg;
    dst_t              rd_tag_reg;
    logic [2:0]        rd_k_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_ok;

    logic [20:0]       code_reg;
    logic [15:0]       ver_reg;
    logic [15:0]       h_reg;
    logic [7:0]        first_reg;
    logic [7:0]        last_reg;
    logic [7:0]        dflt_reg;
    logic [15:0]       w_reg;
    logic [31:0]       ofs_reg;
    logic [10:0]       entry_reg;
    logic [3:0]        rb_reg;
    logic              below_reg;
    logic              entry_oob_reg;
    logic              size_bad_reg;
    logic              bm_oob_reg;

    logic [2:0]        k_reg;
    logic [5:0]        r_reg;
    logic [ADDR_W-1:0] row_base_reg;
    logic [ADDR_W-1:0] bm_addr_reg;
    logic [63:0]       acc_reg;

    logic              m_valid_reg;
    rfg_out_t          m_data_reg;

    logic              ver3;
    logic              in_range;
    logic [7:0]        code_sel;
    logic [7:0]        idx;
    logic [10:0]       entry_calc;
    logic [31:0]       entry_end;
    logic [13:0]       rb_full;
    logic              size_bad;
    logic [10:0]       span;
    logic [32:0]       bm_end;

    assign wr_ok = (32'(s_data.load_address) < 32'(FONT_BYTES));

    always_comb begin
        unique case (cmd.rd_tag)
            DST_VER0:  rd_addr = ADDR_W'(HDR_VERSION_ADDR);
            DST_VER1:  rd_addr = ADDR_W'(HDR_VERSION_ADDR + 1);
            DST_H0:    rd_addr = ADDR_W'(HDR_HEIGHT_ADDR);
            DST_H1:    rd_addr = ADDR_W'(HDR_HEIGHT_ADDR + 1);
            DST_FIRST: rd_addr = ADDR_W'(HDR_FIRST_ADDR);
            DST_LAST:  rd_addr = ADDR_W'(HDR_LAST_ADDR);
            DST_DFLT:  rd_addr = ADDR_W'(HDR_DEFAULT_ADDR);
            DST_W0:    rd_addr = ADDR_W'(entry_reg);
            DST_W1:    rd_addr = ADDR_W'(entry_reg + 11'd1);
            DST_OFS0:  rd_addr = ADDR_W'(entry_reg + 11'd2);
            DST_OFS1:  rd_addr = ADDR_W'(entry_reg + 11'd3);
            DST_OFS2:  rd_addr = ADDR_W'(entry_reg + 11'd4);
            DST_OFS3:  rd_addr = ADDR_W'(entry_reg + 11'd5);
            DST_ROW:   rd_addr = bm_addr_reg;
            default:   rd_addr = '0;
        endcase
    end

    // font memory, one write or one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.wr_en && wr_ok) begin
            mem[ADDR_W'(s_data.load_address)] <= s_data.load_byte;
        end
        if (cmd.rd_tag != DST_NONE) begin
            rd_data_reg <= mem[rd_addr];
        end
        rd_k_reg <= k_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_tag_reg <= DST_NONE;
        end else begin
            rd_tag_reg <= cmd.rd_tag;
        end
    end

    assign ver3     = (ver_reg == 16'(VERSION_3));
    assign in_range = (code_reg >= 21'(first_reg)) && (code_reg <= 21'(last_reg));
    assign code_sel = in_range ? code_reg[7:0] : dflt_reg;
    assign idx      = code_sel - first_reg;
    assign entry_calc = ver3 ? 11'(V3_TABLE_BASE) + 11'(idx) * 11'(V3_ENTRY_BYTES)
                             : 11'(V2_TABLE_BASE) + 11'(idx) * 11'(V2_ENTRY_BYTES);
    assign entry_end = 32'(entry_calc)
                     + (ver3 ? 32'(V3_ENTRY_BYTES) : 32'(V2_ENTRY_BYTES));
    assign rb_full  = 14'((17'(w_reg) + 17'd7) >> 3);
    assign size_bad = (w_reg == 16'd0) || (h_reg == 16'd0)
                   || (h_reg > 16'(MAX_ROWS)) || (rb_full > 14'(MAX_ROW_BYTES));
    assign span     = 11'(rb_reg) * 11'(h_reg[6:0]);
    assign bm_end   = 33'(ofs_reg) + 33'(span);

    always_ff @(posedge aclk) begin
        if (cmd.cap_code) begin
            code_reg <= s_data.char_code;
        end
        if (cmd.eval1) begin
            below_reg     <= (code_sel < first_reg);
            entry_reg     <= entry_calc;
            entry_oob_reg <= (entry_end > 32'(FONT_BYTES));
            ofs_reg       <= '0;
        end
        if (cmd.eval2) begin
            size_bad_reg <= size_bad;
            rb_reg       <= rb_full[3:0];
        end
        if (cmd.eval3) begin
            bm_oob_reg <= (bm_end > 33'(FONT_BYTES));
        end
        unique case (rd_tag_reg)
            DST_VER0:  ver_reg[7:0]   <= rd_data_reg;
            DST_VER1:  ver_reg[15:8]  <= rd_data_reg;
            DST_H0:    h_reg[7:0]     <= rd_data_reg;
            DST_H1:    h_reg[15:8]    <= rd_data_reg;
            DST_FIRST: first_reg      <= rd_data_reg;
            DST_LAST:  last_reg       <= rd_data_reg;
            DST_DFLT:  dflt_reg       <= rd_data_reg;
            DST_W0:    w_reg[7:0]     <= rd_data_reg;
            DST_W1:    w_reg[15:8]    <= rd_data_reg;
            DST_OFS0:  ofs_reg[7:0]   <= rd_data_reg;
            DST_OFS1:  ofs_reg[15:8]  <= rd_data_reg;
            DST_OFS2:  ofs_reg[23:16] <= rd_data_reg;
            DST_OFS3:  ofs_reg[31:24] <= rd_data_reg;
            DST_ROW:   acc_reg[8*rd_k_reg +: 8] <= ~rd_data_reg;
            default: begin
            end
        endcase
        if (cmd.row_init) begin
            row_base_reg <= ADDR_W'(ofs_reg);
            bm_addr_reg  <= ADDR_W'(ofs_reg);
            acc_reg      <= '0;
        end
        if (cmd.rd_tag == DST_ROW) begin
            bm_addr_reg <= ADDR_W'(bm_addr_reg + ADDR_W'(h_reg[6:0]));
        end
        if (cmd.row_emit) begin
            row_base_reg <= row_base_reg + ADDR_W'(1);
            bm_addr_reg  <= row_base_reg + ADDR_W'(1);
            acc_reg      <= '0;
        end
    end

    // column and row counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= '0;
            r_reg <= '0;
        end else begin
            if (cmd.row_init) begin
                k_reg <= '0;
                r_reg <= '0;
            end
            if (cmd.rd_tag == DST_ROW) begin
                k_reg <= k_reg + 3'd1;
            end
            if (cmd.row_emit) begin
                k_reg <= '0;
                r_reg <= r_reg + 6'd1;
            end
        end
    end

    assign status.ver_bad     = !((ver_reg == 16'(VERSION_2)) || ver3);
    assign status.ver3        = ver3;
    assign status.below_first = below_reg;
    assign status.entry_oob   = entry_oob_reg;
    assign status.size_bad    = size_bad_reg;
    assign status.bitmap_oob  = bm_oob_reg;
    assign status.k_last      = ((4'(k_reg) + 4'd1) == rb_reg);
    assign status.r_last      = ((7'(r_reg) + 7'd1) == h_reg[6:0]);
    assign status.out_free    = !m_valid_reg || m_ready;

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.row_emit || cmd.fault_emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.row_emit) begin
            m_data_reg.row_bits     <= acc_reg;
            m_data_reg.row_number   <= r_reg;
            m_data_reg.glyph_width  <= w_reg;
            m_data_reg.glyph_height <= h_reg;
            m_data_reg.last_row     <= status.r_last;
            m_data_reg.fault        <= FLT_OK;
        end else if (cmd.fault_emit) begin
            m_data_reg.row_bits     <= '0;
            m_data_reg.row_number   <= '0;
            m_data_reg.glyph_width  <= '0;
            m_data_reg.glyph_height <= '0;
            m_data_reg.last_row     <= 1'b1;
            m_data_reg.fault        <= cmd.fault_code;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### sv/raster_font_glyph_fetch.sv
// raster_font_glyph_fetch: top level of the raster font character generator
// a load beat leaves the input side open; a render closes it until its
// last row beat or its fault beat has been emitted
// row bytes come through the single font memory read port, one byte per cycle
// while a row is fetched; each finished row waits for a free result register
// a fault is reported as one beat
// reset clears the control state; font memory holds garbage until loaded
`timescale 1ns / 1ps

module raster_font_glyph_fetch import rfg_pkg::*; #(
    parameter int FONT_BYTES    = 65536,
    parameter int MAX_ROWS      = 64,
    parameter int MAX_ROW_BYTES = 8
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rfg_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rfg_out_t m_data
);

    rfg_cmd_t    cmd;
    rfg_status_t status;

    rfg_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_data.command),
        .s_ready   (s_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rfg_datapath #(
        .FONT_BYTES    (FONT_BYTES),
        .MAX_ROWS      (MAX_ROWS),
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### sv/rfg_checker.sv
// rfg_checker: port-level assertions for raster_font_glyph_fetch and its bind
`timescale 1ns / 1ps

module rfg_checker import rfg_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input rfg_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input rfg_out_t m_data
);

    // a stalled result beat holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // fault beats are single, empty and final
    a_fault_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.fault != FLT_OK) |->
            m_data.last_row && (m_data.row_number == 6'd0)
            && (m_data.row_bits == 64'd0) && (m_data.glyph_height == 16'd0))
        else $error("malformed fault beat");

    // row numbering agrees with height and end marker
    a_row_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.fault == FLT_OK) |->
            (16'(m_data.row_number) < m_data.glyph_height)
            && (m_data.last_row == ((16'(m_data.row_number) + 16'd1)
                                    == m_data.glyph_height)))
        else $error("row number inconsistent with glyph height");

    // a render beat closes the input side
    a_render_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.command |=> !s_ready)
        else $error("input accepted during render");

    // a load beat leaves the input side open
    a_load_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_data.command |=> s_ready)
        else $error("input closed after load beat");

endmodule

bind raster_font_glyph_fetch rfg_checker u_rfg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### verif/testbench.sv
// testbench: self-checking regression for the raster font glyph fetch block
`timescale 1ns / 1ps

module testbench;
    import rfg_pkg::*;

    localparam int          CLK_HALF       = 2;
    localparam int          RESET_CYCLES   = 6;
    localparam int          FONT_SIZE      = 65536;
    localparam int          ROW_LIMIT      = 64;
    localparam int          ROW_BYTE_LIMIT = 8;
    localparam int          ITEM_TARGET    = 280;
    localparam int          BITMAP_LO      = 1700;
    localparam int          BITMAP_HI      = 5599;
    localparam int          DRAIN_CYCLES   = 700;
    localparam int          CYCLE_LIMIT    = 2000000;
    localparam int          REPORT_LIMIT   = 10;
    localparam logic        CMD_LOAD       = 1'b0;
    localparam logic        CMD_RENDER     = 1'b1;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    rfg_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    rfg_out_t m_data;

    // stimulus planning image, tracks which bytes have been loaded
    bit [7:0] plan_mem   [0:FONT_SIZE-1];
    bit       plan_known [0:FONT_SIZE-1];
    // font image as seen by the block, updated on accepted beats
    bit [7:0] font_image [0:FONT_SIZE-1];

    rfg_in_t  pending_beats [$];
    rfg_out_t expected_rows [$];

    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          burst_left     = 0;
    int          gap_left       = 0;
    int          pattern_left   = 0;
    logic [15:0] stall_pattern  = 16'hFFFF;

    raster_font_glyph_fetch #(
        .FONT_BYTES    (FONT_SIZE),
        .MAX_ROWS      (ROW_LIMIT),
        .MAX_ROW_BYTES (ROW_BYTE_LIMIT)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // ---------------- stimulus planning ----------------

    function automatic int unsigned plan16(input int unsigned addr);
        return {plan_mem[addr + 1], plan_mem[addr]};
    endfunction

    task automatic put_byte(input int unsigned addr, input logic [7:0] val);
        rfg_in_t beat;
        beat.command      = CMD_LOAD;
        beat.load_address = addr[15:0];
        beat.load_byte    = val;
        beat.char_code    = 21'($urandom_range(0, 21'h1FFFFF));
        pending_beats.push_back(beat);
        plan_mem[addr]   = val;
        plan_known[addr] = 1'b1;
    endtask

    task automatic put_word(input int unsigned addr, input logic [15:0] val);
        put_byte(addr, val[7:0]);
        put_byte(addr + 1, val[15:8]);
    endtask

    task automatic need_byte(input int unsigned addr);
        if (!plan_known[addr]) begin
            put_byte(addr, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic set_header(input logic [15:0] ver, input logic [15:0] hgt,
                              input logic [7:0] first, input logic [7:0] last,
                              input logic [7:0] dflt);
        put_word(HDR_VERSION_ADDR, ver);
        put_word(HDR_HEIGHT_ADDR, hgt);
        put_byte(HDR_FIRST_ADDR, first);
        put_byte(HDR_LAST_ADDR, last);
        put_byte(HDR_DEFAULT_ADDR, dflt);
    endtask

    // table layout follows the version currently planned in the header
    task automatic set_entry(input int unsigned idx, input logic [15:0] wid,
                             input logic [31:0] ofst);
        int unsigned base;
        if (plan16(HDR_VERSION_ADDR) == VERSION_3) begin
            base = V3_TABLE_BASE + V3_ENTRY_BYTES * idx;
            put_word(base, wid);
            put_word(base + 2, ofst[15:0]);
            put_word(base + 4, ofst[31:16]);
        end else begin
            base = V2_TABLE_BASE + V2_ENTRY_BYTES * idx;
            put_word(base, wid);
            put_word(base + 2, ofst[15:0]);
        end
    endtask

    // loads every byte the render will fetch that was never written, then queues it
    task automatic put_render(input logic [20:0] code);
        int unsigned     ver, hgt, first, last, sel, base, wid, rb;
        longint unsigned ofst;
        rfg_in_t         beat;
        need_byte(HDR_VERSION_ADDR);
        need_byte(HDR_VERSION_ADDR + 1);
        need_byte(HDR_HEIGHT_ADDR);
        need_byte(HDR_HEIGHT_ADDR + 1);
        need_byte(HDR_FIRST_ADDR);
        need_byte(HDR_LAST_ADDR);
        need_byte(HDR_DEFAULT_ADDR);
        ver   = plan16(HDR_VERSION_ADDR);
        hgt   = plan16(HDR_HEIGHT_ADDR);
        first = plan_mem[HDR_FIRST_ADDR];
        last  = plan_mem[HDR_LAST_ADDR];
        sel   = code;
        if (sel < first || sel > last) begin
            sel = plan_mem[HDR_DEFAULT_ADDR];
        end
        if ((ver == VERSION_2 || ver == VERSION_3) && sel >= first) begin
            if (ver == VERSION_2) begin
                base = V2_TABLE_BASE + V2_ENTRY_BYTES * (sel - first);
                for (int i = 0; i < V2_ENTRY_BYTES; i++) need_byte(base + i);
                ofst = plan16(base + 2);
            end else begin
                base = V3_TABLE_BASE + V3_ENTRY_BYTES * (sel - first);
                for (int i = 0; i < V3_ENTRY_BYTES; i++) need_byte(base + i);
                ofst = plan16(base + 2) | (longint'(plan16(base + 4)) << 16);
            end
            wid = plan16(base);
            rb  = (wid + 7) >> 3;
            if (wid != 0 && hgt != 0 && hgt <= ROW_LIMIT && rb <= ROW_BYTE_LIMIT &&
                ofst + rb * hgt <= FONT_SIZE) begin
                for (int k = 0; k < rb; k++) begin
                    for (int r = 0; r < hgt; r++) need_byte(int'(ofst + k * hgt + r));
                end
            end
        end
        beat.command      = CMD_RENDER;
        beat.load_address = 16'($urandom_range(0, 16'hFFFF));
        beat.load_byte    = 8'($urandom_range(0, 255));
        beat.char_code    = code;
        pending_beats.push_back(beat);
    endtask

    // ---------------- glyph row prediction ----------------

    function automatic longint unsigned img8(input longint unsigned addr);
        return (addr < FONT_SIZE) ? longint'(font_image[addr[15:0]]) : 0;
    endfunction

    function automatic longint unsigned img16(input longint unsigned addr);
        return img8(addr) | (img8(addr + 1) << 8);
    endfunction

    task automatic push_fault(input fault_t code);
        rfg_out_t row;
        row          = '0;
        row.last_row = 1'b1;
        row.fault    = code;
        expected_rows.push_back(row);
    endtask

    task automatic render_rows(input logic [20:0] code);
        longint unsigned ver, hgt, first, last, sel, entry, wid, ofst, rb;
        logic [63:0]     bits;
        rfg_out_t        row;
        ver = img16(HDR_VERSION_ADDR);
        if (ver != VERSION_2 && ver != VERSION_3) begin
            push_fault(FLT_VERSION);
            return;
        end
        hgt   = img16(HDR_HEIGHT_ADDR);
        first = img8(HDR_FIRST_ADDR);
        last  = img8(HDR_LAST_ADDR);
        sel   = code;
        if (sel < first || sel > last) begin
            sel = img8(HDR_DEFAULT_ADDR);
        end
        if (sel < first) begin
            push_fault(FLT_RANGE);
            return;
        end
        if (ver == VERSION_2) begin
            entry = V2_TABLE_BASE + (sel - first) * V2_ENTRY_BYTES;
            if (entry + V2_ENTRY_BYTES > FONT_SIZE) begin
                push_fault(FLT_RANGE);
                return;
            end
            ofst = img16(entry + 2);
        end else begin
            entry = V3_TABLE_BASE + (sel - first) * V3_ENTRY_BYTES;
            if (entry + V3_ENTRY_BYTES > FONT_SIZE) begin
                push_fault(FLT_RANGE);
                return;
            end
            ofst = img16(entry + 2) | (img16(entry + 4) << 16);
        end
        wid = img16(entry);
        rb  = (wid + 7) >> 3;
        if (wid == 0 || hgt == 0 || hgt > ROW_LIMIT || rb > ROW_BYTE_LIMIT) begin
            push_fault(FLT_SIZE);
            return;
        end
        if (ofst + rb * hgt > FONT_SIZE) begin
            push_fault(FLT_RANGE);
            return;
        end
        for (longint unsigned r = 0; r < hgt; r++) begin
            bits = '0;
            for (longint unsigned k = 0; k < rb; k++) begin
                bits[8 * k +: 8] = ~8'(img8(ofst + k * hgt + r));
            end
            row.row_bits     = bits;
            row.row_number   = 6'(r);
            row.glyph_width  = 16'(wid);
            row.glyph_height = 16'(hgt);
            row.last_row     = (r + 1 == hgt);
            row.fault        = FLT_OK;
            expected_rows.push_back(row);
        end
    endtask

    task automatic apply_beat(input rfg_in_t beat);
        if (beat.command == CMD_LOAD) begin
            font_image[beat.load_address] = beat.load_byte;
        end else begin
            render_rows(beat.char_code);
        end
    endtask

    task automatic check_row(input rfg_out_t got);
        rfg_out_t want;
        if (expected_rows.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("%0t: row beat with none expected: bits %h row %0d w %0d",
                         $time, got.row_bits, got.row_number, got.glyph_width);
                $display("%0t:   h %0d last %0d fault %0d",
                         $time, got.glyph_height, got.last_row, got.fault);
            end
            return;
        end
        want = expected_rows.pop_front();
        if (got.row_bits !== want.row_bits || got.row_number !== want.row_number ||
            got.glyph_width !== want.glyph_width || got.glyph_height !== want.glyph_height ||
            got.last_row !== want.last_row || got.fault !== want.fault) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("%0t: expected bits %h row %0d w %0d h %0d last %0d fault %0d",
                         $time, want.row_bits, want.row_number, want.glyph_width,
                         want.glyph_height, want.last_row, want.fault);
                $display("%0t: actual   bits %h row %0d w %0d h %0d last %0d fault %0d",
                         $time, got.row_bits, got.row_number, got.glyph_width,
                         got.glyph_height, got.last_row, got.fault);
            end
        end
    endtask

    // ---------------- driver ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready) begin
                apply_beat(s_data);
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0 || pending_beats.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    s_valid <= 1'b0;
                end else begin
                    s_data  <= pending_beats.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                check_row(m_data);
            end
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0: stall_pattern = 16'hFFFF;
                    1: stall_pattern = 16'($urandom);
                    2: stall_pattern = 16'h0101;
                    default: stall_pattern = 16'h0001;
                endcase
            end else begin
                pattern_left--;
            end
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            m_ready <= stall_pattern[0];
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("raster_font_glyph_fetch regression: fail");
            $finish;
        end
    end

    // ---------------- stimulus and end of run ----------------

    initial begin
        int unsigned     pick, r, first, last, idx, lo, hi;
        logic [15:0]     wid;
        longint unsigned ofst;
        logic [20:0]     code;

        // version 2 font, 4 rows, codes 32..126, default '?'
        set_header(VERSION_2, 16'd4, 8'd32, 8'd126, 8'd63);
        set_entry(65 - 32, 16'd8, 32'd2000);
        set_entry(63 - 32, 16'd5, 32'd2004);
        set_entry(0, 16'd1, 32'd2008);
        set_entry(126 - 32, 16'd16, 32'd2012);
        put_render(21'd65);
        put_render(21'd32);
        put_render(21'd126);
        put_render(21'd31);
        put_render(21'd127);
        put_render(21'h1FFFFF);
        put_render(21'd0);
        // widest glyph, too wide, empty
        set_entry(66 - 32, 16'd64, 32'd2020);
        put_render(21'd66);
        set_entry(67 - 32, 16'd65, 32'd2400);
        put_render(21'd67);
        set_entry(68 - 32, 16'd0, 32'd2400);
        put_render(21'd68);
        // bitmap ending exactly at the top of memory, then four bytes past it
        set_entry(69 - 32, 16'd3, FONT_SIZE - 4);
        put_render(21'd69);
        set_entry(70 - 32, 16'd9, FONT_SIZE - 4);
        put_render(21'd70);
        // height extremes
        put_word(HDR_HEIGHT_ADDR, 16'd64);
        put_render(21'd65);
        put_word(HDR_HEIGHT_ADDR, 16'd1);
        put_render(21'd65);
        put_word(HDR_HEIGHT_ADDR, 16'd0);
        put_render(21'd65);
        put_word(HDR_HEIGHT_ADDR, 16'd65);
        put_render(21'd65);
        put_word(HDR_HEIGHT_ADDR, 16'hFFFF);
        put_render(21'd65);
        put_word(HDR_HEIGHT_ADDR, 16'd4);
        // default character below the first character
        put_byte(HDR_DEFAULT_ADDR, 8'd10);
        put_render(21'd5);
        put_byte(HDR_DEFAULT_ADDR, 8'd63);
        // unsupported versions
        put_word(HDR_VERSION_ADDR, 16'h0000);
        put_render(21'd65);
        put_word(HDR_VERSION_ADDR, 16'hFFFF);
        put_render(21'd65);
        // version 3 font, full code range, 32 bit offsets
        set_header(VERSION_3, 16'd4, 8'd0, 8'd255, 8'd255);
        set_entry(0, 16'd12, 32'd3000);
        set_entry(255, 16'd24, 32'h0000_0C00);
        set_entry(65, 16'd8, 32'h0001_0000);
        set_entry(66, 16'd8, 32'hFFFF_FFFF);
        put_render(21'd0);
        put_render(21'd255);
        put_render(21'h100);
        put_render(21'd65);
        put_render(21'd66);

        while (pending_beats.size() < ITEM_TARGET) begin
            pick  = $urandom_range(0, 99);
            first = plan_mem[HDR_FIRST_ADDR];
            last  = plan_mem[HDR_LAST_ADDR];
            if (pick < 55) begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    code = 21'($urandom_range(first, last));
                end else if (r < 85) begin
                    code = 21'($urandom_range(0, 255));
                end else if (r < 95) begin
                    code = 21'($urandom_range(0, 21'h1FFFFF));
                end else begin
                    case ($urandom_range(0, 3))
                        0: code = 21'(first);
                        1: code = 21'(last);
                        2: code = 21'(first - 1);
                        default: code = 21'(last + 1);
                    endcase
                end
                put_render(code);
            end else if (pick < 70) begin
                idx = (last >= first) ? $urandom_range(0, last - first)
                                      : $urandom_range(0, 255);
                r = $urandom_range(0, 99);
                if (r < 70) wid = 16'($urandom_range(1, 16));
                else if (r < 88) wid = 16'($urandom_range(17, 40));
                else if (r < 95) wid = 16'($urandom_range(41, 64));
                else if (r < 97) wid = 16'd0;
                else wid = 16'($urandom_range(65, 16'hFFFF));
                r = $urandom_range(0, 99);
                if (r < 90) ofst = $urandom_range(BITMAP_LO, BITMAP_HI - 100);
                else if (r < 95) ofst = FONT_SIZE - $urandom_range(1, 600);
                else ofst = $urandom;
                set_entry(idx, wid, 32'(ofst));
            end else if (pick < 80) begin
                case ($urandom_range(0, 2))
                    0: begin
                        r = $urandom_range(0, 99);
                        if (r < 60) put_word(HDR_HEIGHT_ADDR, 16'($urandom_range(1, 12)));
                        else if (r < 85) put_word(HDR_HEIGHT_ADDR, 16'($urandom_range(13, 24)));
                        else if (r < 95) put_word(HDR_HEIGHT_ADDR, 16'($urandom_range(25, 64)));
                        else if (r < 97) put_word(HDR_HEIGHT_ADDR, 16'd0);
                        else put_word(HDR_HEIGHT_ADDR, 16'($urandom_range(65, 16'hFFFF)));
                    end
                    1: begin
                        lo = $urandom_range(0, 64);
                        hi = lo + $urandom_range(0, 191);
                        put_byte(HDR_FIRST_ADDR, 8'(lo));
                        put_byte(HDR_LAST_ADDR, 8'(hi));
                        r = $urandom_range(0, 99);
                        if (r < 80) begin
                            put_byte(HDR_DEFAULT_ADDR, 8'($urandom_range(lo, hi)));
                        end else if (r < 90 && lo > 0) begin
                            put_byte(HDR_DEFAULT_ADDR, 8'($urandom_range(0, lo - 1)));
                        end else begin
                            put_byte(HDR_DEFAULT_ADDR, 8'($urandom_range(0, 255)));
                        end
                    end
                    default: begin
                        r = $urandom_range(0, 99);
                        if (r < 45) put_word(HDR_VERSION_ADDR, 16'(VERSION_2));
                        else if (r < 90) put_word(HDR_VERSION_ADDR, 16'(VERSION_3));
                        else put_word(HDR_VERSION_ADDR, 16'($urandom_range(0, 16'hFFFF)));
                    end
                endcase
            end else if (pick < 92) begin
                put_byte($urandom_range(BITMAP_LO, BITMAP_HI), 8'($urandom_range(0, 255)));
            end else begin
                put_byte($urandom_range(0, FONT_SIZE - 1), 8'($urandom_range(0, 255)));
            end
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        @(negedge aclk);
        while (pending_beats.size() != 0 || s_valid || expected_rows.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && expected_rows.size() == 0) begin
            $display("raster_font_glyph_fetch regression: pass");
        end else begin
            $display("raster_font_glyph_fetch regression: fail");
        end
        $finish;
    end

endmodule
